### rtl/base58_encoder_unit_defines.svh
// Assertion macros shared by the base58 encoder checker.
`ifndef BASE58_ENCODER_UNIT_DEFINES_SVH
`define BASE58_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define B58_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define B58_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define B58_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/b58enc_pkg.sv
// Shared types, constants and the alphabet lookup of the base58 encoder.
package b58enc_pkg;

   localparam int IN_BYTES  = 25;
   localparam int OUT_CHARS = 34;

   localparam int BYTE_CNT_W = (IN_BYTES > 1) ? $clog2(IN_BYTES) : 1;
   localparam int CHAR_CNT_W = (OUT_CHARS > 1) ? $clog2(OUT_CHARS) : 1;

   // Reciprocal of 58 scaled by 2**20; exact for dividends below 2**14.
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_MULT  = 18079;

   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_DEPTH = 2 ** QUEUE_PTR_W;

   typedef logic [7:0] b58enc_byte_type;
   typedef logic [6:0] b58enc_char_type;
   typedef logic [5:0] b58enc_digit_type;

   typedef struct packed {
      b58enc_byte_type data_byte;
      logic            last;
   } b58enc_entry_type;

   function automatic b58enc_char_type digit_to_char(input b58enc_digit_type digit);
      b58enc_char_type code;
      if (digit < 6'd9) begin
         code = 7'd49 + 7'(digit);
      end else if (digit < 6'd17) begin
         code = 7'd65 + 7'(digit - 6'd9);
      end else if (digit < 6'd22) begin
         code = 7'd74 + 7'(digit - 6'd17);
      end else if (digit < 6'd33) begin
         code = 7'd80 + 7'(digit - 6'd22);
      end else if (digit < 6'd44) begin
         code = 7'd97 + 7'(digit - 6'd33);
      end else if (digit < 6'd58) begin
         code = 7'd109 + 7'(digit - 6'd44);
      end else begin
         code = 7'd49;
      end
      return code;
   endfunction

endpackage

### rtl/b58enc_ifs.sv
// Valid/ready channel interfaces for the byte input and the character output.
interface b58enc_req_if;
   import b58enc_pkg::*;
   logic            valid;
   logic            ready;
   b58enc_byte_type data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface b58enc_rsp_if;
   import b58enc_pkg::*;
   logic            valid;
   logic            ready;
   b58enc_char_type char_code;
   logic            final_char;
   modport source (output valid, output char_code, output final_char, input ready);
   modport sink (input valid, input char_code, input final_char, output ready);
endinterface

### rtl/b58enc_front.sv
// Front end: accepts input bytes and tags the one that completes a string.
module b58enc_front (
   input  logic                         clock,
   input  logic                         reset,
   b58enc_req_if.sink                   req_ch,
   output logic                         push_valid,
   output b58enc_pkg::b58enc_entry_type push_entry,
   input  logic                         push_ready
);
   import b58enc_pkg::*;

   logic [BYTE_CNT_W-1:0] count_ff;
   logic [BYTE_CNT_W-1:0] count_in;
   logic                  accept;
   logic                  is_last;

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;
   assign is_last      = (count_ff >= BYTE_CNT_W'(IN_BYTES - 1));

   assign push_valid            = req_ch.valid;
   assign push_entry.data_byte  = req_ch.data_byte;
   assign push_entry.last       = is_last;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = is_last ? '0 : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### rtl/b58enc_queue.sv
// Two-entry queue between the front end and the encoding engine.
module b58enc_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  b58enc_pkg::b58enc_entry_type push_entry,
   output logic                         push_ready,
   output logic                         pop_valid,
   output b58enc_pkg::b58enc_entry_type pop_entry,
   input  logic                         pop_ready
);
   import b58enc_pkg::*;

   b58enc_entry_type       entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_PTR_W:0]   fill_ff;
   logic [QUEUE_PTR_W:0]   fill_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (fill_ff != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### rtl/b58enc_back.sv
// Encoding engine: loads the number, divides it by 58 byte by byte, emits characters.
module b58enc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   input  b58enc_pkg::b58enc_entry_type pop_entry,
   output logic                         pop_ready,
   b58enc_rsp_if.source                 rsp_ch
);
   import b58enc_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type             state_ff;
   state_type             state_in;
   b58enc_byte_type       number_ff [IN_BYTES];
   b58enc_digit_type      digits_ff [OUT_CHARS];
   b58enc_digit_type      rem_ff;
   b58enc_digit_type      rem_in;
   logic [BYTE_CNT_W-1:0] byte_idx_ff;
   logic [BYTE_CNT_W-1:0] byte_idx_in;
   logic [CHAR_CNT_W-1:0] char_idx_ff;
   logic [CHAR_CNT_W-1:0] char_idx_in;

   logic [13:0]           dividend;
   logic [28:0]           product;
   b58enc_byte_type       quotient;
   logic [13:0]           quot_x58;
   logic [13:0]           rem_wide;
   b58enc_digit_type      rem_next;
   logic                  load_fire;
   logic                  div_step;
   logic                  pass_done;
   logic                  emit_fire;
   logic                  last_char;
   logic                  last_pass;

   // One step of the long division: leading byte plus the running remainder.
   assign dividend = {rem_ff, number_ff[0]};
   assign product  = 29'(dividend) * 29'(RECIP_MULT);
   assign quotient = product[RECIP_SHIFT +: 8];
   assign quot_x58 = {quotient, 6'b0} - {4'b0, quotient, 2'b0} - {5'b0, quotient, 1'b0};
   assign rem_wide = dividend - quot_x58;
   assign rem_next = rem_wide[5:0];

   assign pop_ready = (state_ff == ST_LOAD);
   assign load_fire = pop_valid && pop_ready;
   assign div_step  = (state_ff == ST_DIVIDE);
   assign pass_done = div_step && (byte_idx_ff == BYTE_CNT_W'(IN_BYTES - 1));
   assign last_char = (char_idx_ff == CHAR_CNT_W'(OUT_CHARS - 1));
   assign last_pass = (char_idx_ff == CHAR_CNT_W'(OUT_CHARS - 1));

   assign rsp_ch.valid      = (state_ff == ST_EMIT);
   assign rsp_ch.char_code  = digit_to_char(digits_ff[0]);
   assign rsp_ch.final_char = last_char;
   assign emit_fire         = rsp_ch.valid && rsp_ch.ready;

   // The character counter doubles as the pass counter while dividing.
   always_comb begin
      state_in    = state_ff;
      rem_in      = rem_ff;
      byte_idx_in = byte_idx_ff;
      char_idx_in = char_idx_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_fire && pop_entry.last) begin
               state_in    = ST_DIVIDE;
               rem_in      = '0;
               byte_idx_in = '0;
               char_idx_in = '0;
            end
         end
         ST_DIVIDE: begin
            if (pass_done) begin
               rem_in      = '0;
               byte_idx_in = '0;
               if (last_pass) begin
                  state_in    = ST_EMIT;
                  char_idx_in = '0;
               end else begin
                  char_idx_in = char_idx_ff + 1'b1;
               end
            end else begin
               rem_in      = rem_next;
               byte_idx_in = byte_idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               char_idx_in = char_idx_ff + 1'b1;
               if (last_char) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // The number rotates by one byte per load or division step, so after a
   // full pass the quotient bytes are back in their original order.
   always_ff @(posedge clock) begin
      if (load_fire || div_step) begin
         for (int i = 0; i < IN_BYTES - 1; i++) begin
            number_ff[i] <= number_ff[i + 1];
         end
         number_ff[IN_BYTES - 1] <= load_fire ? pop_entry.data_byte : quotient;
      end
   end

   // Digits enter at the head, so the most significant ends up in front.
   always_ff @(posedge clock) begin
      if (pass_done) begin
         for (int i = 1; i < OUT_CHARS; i++) begin
            digits_ff[i] <= digits_ff[i - 1];
         end
         digits_ff[0] <= rem_next;
      end else if (emit_fire) begin
         for (int i = 0; i < OUT_CHARS - 1; i++) begin
            digits_ff[i] <= digits_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         byte_idx_ff <= '0;
         char_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         byte_idx_ff <= byte_idx_in;
         char_idx_ff <= char_idx_in;
      end
   end

endmodule

### rtl/base58_encoder_unit.sv
// Base58 encoder. Input bytes arrive one per transaction, most significant
// first; every 25th byte closes a string, and the unit then answers with 34
// ASCII characters of the base58 alphabet, most significant digit first, with
// final_char set on the last one. Leading zero digits come out as '1'. A byte
// is taken whenever the two-entry queue has room, so the front end keeps
// accepting up to two bytes of the next string while the engine works. The
// engine loads one byte per cycle while the queue holds bytes, then runs its
// shared divide-by-58 step over 34 long-division passes of 25 bytes each (one
// byte of one pass per cycle), then emits one character per cycle while the
// sink is ready.
module base58_encoder_unit (
   input  logic          clock,
   input  logic          reset,
   b58enc_req_if.sink    req_ch,
   b58enc_rsp_if.source  rsp_ch
);
   import b58enc_pkg::*;

   logic             push_valid;
   logic             push_ready;
   b58enc_entry_type push_entry;
   logic             pop_valid;
   logic             pop_ready;
   b58enc_entry_type pop_entry;

   b58enc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   b58enc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   b58enc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

### rtl/b58enc_checker.sv
// Port-level checker for the base58 encoder and its bind to the top level.
`include "base58_encoder_unit_defines.svh"

module b58enc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] char_code,
   input logic       final_char
);

   logic       rsp_stall;
   logic [7:0] rsp_payload;
   logic       char_legal;
   logic       final_done;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {char_code, final_char};
   // The digits 0, the letters O and I and the lowercase l are not in the alphabet.
   assign char_legal  = char_code >= 7'd49 && char_code <= 7'd122 && char_code != 7'd58 &&
                        char_code != 7'd73 && char_code != 7'd79 && char_code != 7'd108;
   assign final_done  = rsp_valid && rsp_ready && final_char;

   `B58_ASSERT_NEXT(a_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled output changed")
   `B58_ASSERT_NOW(a_alphabet, rsp_valid, char_legal, "character outside the alphabet")
   `B58_ASSERT_NEXT_ALWAYS(a_reset_quiet, reset, !rsp_valid, "output valid right after reset")
   `B58_ASSERT_NEXT(a_final_gap, final_done, !rsp_valid, "valid right after the final character")

endmodule

bind base58_encoder_unit b58enc_checker u_b58enc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .char_code  (rsp_ch.char_code),
   .final_char (rsp_ch.final_char)
);

### bench/base58_encoder_unit_test.sv
// Self-checking testbench for base58_encoder_unit: byte strings in, predicted characters out.
module base58_encoder_unit_test;
   import b58enc_pkg::*;

   localparam int STALL_LIMIT    = 5000;
   localparam int RANDOM_STRINGS = 6;
   localparam int MAX_REPORTS    = 40;
   localparam int SETTLE_CYCLES  = 100;

   typedef enum {SHAPE_SMALL, SHAPE_OVERSIZE, SHAPE_UNIFORM} string_shape_type;

   class b58_char_ledger_type;
      b58enc_byte_type collected[IN_BYTES];
      int              collected_count = 0;
      b58enc_char_type expected_chars[$];
      logic            expected_final[$];
      int              chars_seen = 0;
      int              mismatches = 0;

      task report(input string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
      endtask

      function int pending();
         return expected_chars.size();
      endfunction

      // Repeated long division by 58 of the collected string; the first
      // remainder is the least significant digit. Digits beyond the last
      // character position are simply never produced.
      function void encode_string();
         int    dividend[IN_BYTES];
         int    remainder;
         int    acc;
         int    digits[OUT_CHARS];
         string symbols = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
         for (int i = 0; i < IN_BYTES; i++) dividend[i] = collected[i];
         for (int k = OUT_CHARS - 1; k >= 0; k--) begin
            remainder = 0;
            for (int i = 0; i < IN_BYTES; i++) begin
               acc = remainder * 256 + dividend[i];
               dividend[i] = acc / 58;
               remainder = acc % 58;
            end
            digits[k] = remainder;
         end
         for (int k = 0; k < OUT_CHARS; k++) begin
            expected_chars.push_back(7'(symbols[digits[k]]));
            expected_final.push_back(k == OUT_CHARS - 1);
         end
      endfunction

      function void note_byte(input b58enc_byte_type value);
         collected[collected_count] = value;
         collected_count++;
         if (collected_count == IN_BYTES) begin
            collected_count = 0;
            encode_string();
         end
      endfunction

      task check_char(input b58enc_char_type code, input logic last);
         b58enc_char_type want_code;
         logic            want_last;
         chars_seen++;
         if (expected_chars.size() == 0) begin
            report($sformatf("character %0d: 0x%02h arrived with none expected",
                             chars_seen, code));
            return;
         end
         want_code = expected_chars.pop_front();
         want_last = expected_final.pop_front();
         if (code !== want_code)
            report($sformatf("character %0d: char_code 0x%02h, expected 0x%02h",
                             chars_seen, code, want_code));
         if (last !== want_last)
            report($sformatf("character %0d: final_char %0b, expected %0b",
                             chars_seen, last, want_last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 12;
   int   recv_idle_pct = 75;
   int   quiet_cycles = 0;

   b58_char_ledger_type ledger = new();

   b58enc_req_if req_ch();
   b58enc_rsp_if rsp_ch();

   base58_encoder_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #4 clock = ~clock;

   always @(negedge clock)
      rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);

   // Inputs are noted before outputs are checked so that a transaction that
   // completes a string is predicted before any of its characters is seen.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) ledger.note_byte(req_ch.data_byte);
         if (rsp_ch.valid && rsp_ch.ready) ledger.check_char(rsp_ch.char_code, rsp_ch.final_char);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("base58_encoder_unit_test NOT OK");
               $finish;
            end
         end
      end
   end

   task automatic send_byte(input b58enc_byte_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.data_byte = value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_string(input b58enc_byte_type bytes_in[IN_BYTES]);
      for (int i = 0; i < IN_BYTES; i++) send_byte(bytes_in[i]);
   endtask

   task automatic wait_for_drain();
      while (ledger.pending() != 0) @(negedge clock);
   endtask

   // Small numbers give leading '1' characters; oversize ones exceed what
   // 34 digits can hold, so the top of the number is dropped.
   function automatic void fill_string(input string_shape_type shape,
                                       output b58enc_byte_type bytes_out[IN_BYTES]);
      int zeros;
      zeros = (shape == SHAPE_SMALL) ? $urandom_range(1, IN_BYTES) : 0;
      for (int i = 0; i < IN_BYTES; i++)
         bytes_out[i] = (i < zeros) ? 8'h00 : 8'($urandom_range(0, 255));
      if (shape == SHAPE_OVERSIZE) bytes_out[0] = 8'($urandom_range(8'hA0, 8'hFF));
   endfunction

   initial begin
      b58enc_byte_type pattern[IN_BYTES];
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Both byte extremes, with a top byte large enough to overflow 34 digits.
      for (int i = 0; i < IN_BYTES; i++) pattern[i] = 8'h00;
      pattern[0] = 8'hFF;
      pattern[IN_BYTES - 1] = 8'hFF;
      send_string(pattern);

      for (int s = 0; s < RANDOM_STRINGS; s++) begin
         if (s == 2) begin
            send_idle_pct = 75;
            recv_idle_pct = 12;
         end
         if (s == 4) begin
            req_ch.valid = 1'b0;
            wait_for_drain();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         fill_string(string_shape_type'(s % 3), pattern);
         send_string(pattern);
      end
      req_ch.valid = 1'b0;

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (ledger.mismatches == 0) begin
         $display("base58_encoder_unit_test OK");
      end else begin
         $display("base58_encoder_unit_test NOT OK");
      end
      $finish;
   end

endmodule
